FILE: design/pls_pkg.sv
// Shared types and codes for the positional list store.
package pls_pkg;

	localparam int CAPACITY_DEF = 16;

	// operation codes
	localparam logic [2:0] OP_INS_FRONT = 3'd0;
	localparam logic [2:0] OP_INS_BACK  = 3'd1;
	localparam logic [2:0] OP_INS_POS   = 3'd2;
	localparam logic [2:0] OP_DEL_FRONT = 3'd3;
	localparam logic [2:0] OP_DEL_BACK  = 3'd4;
	localparam logic [2:0] OP_DEL_POS   = 3'd5;
	localparam logic [2:0] OP_READ_ALL  = 3'd6;

	// status codes
	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_INVALID = 2'd1;
	localparam logic [1:0] STS_EMPTY   = 2'd2;
	localparam logic [1:0] STS_FULL    = 2'd3;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] element_value;
		logic [4:0]         position;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [4:0]         element_count;
		logic signed [31:0] read_value;
		logic               last_result;
	} rsp_t;

	// what every cell does this cycle
	typedef enum logic [1:0] {
		CM_HOLD = 2'd0,
		CM_INS  = 2'd1,
		CM_DEL  = 2'd2,
		CM_ROT  = 2'd3
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t         mode;
		logic signed [31:0] ins_value;
	} cell_ctl_t;

endpackage

FILE: design/pls_cell.sv
// One storage cell of the list row: holds one element, moves with its neighbors.
module pls_cell #(
	parameter int CAPACITY = pls_pkg::CAPACITY_DEF,
	parameter int CELL_IDX = 0
) (
	input  logic                            clk,
	input  pls_pkg::cell_ctl_t              ctl,
	input  logic [$clog2(CAPACITY)-1:0]     idx,
	input  logic [$clog2(CAPACITY)-1:0]     last_idx,
	input  logic signed [31:0]              left_value,
	input  logic signed [31:0]              right_value,
	input  logic signed [31:0]              head_value,
	output logic signed [31:0]              value
);
	import pls_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

	logic signed [31:0] val_q;

	always_ff @(posedge clk) begin
		unique case (ctl.mode)
			CM_INS: begin
				if (MY_IDX > idx) begin
					val_q <= left_value;
				end else if (MY_IDX == idx) begin
					val_q <= ctl.ins_value;
				end
			end
			CM_DEL: begin
				if (MY_IDX >= idx) begin
					val_q <= right_value;
				end
			end
			CM_ROT: begin
				// front element wraps around to the tail slot
				if (MY_IDX < last_idx) begin
					val_q <= right_value;
				end else if (MY_IDX == last_idx) begin
					val_q <= head_value;
				end
			end
			default: begin
			end
		endcase
	end

	assign value = val_q;

endmodule

FILE: design/pls_cell_row.sv
// Row of list cells with neighbor wiring; cell 0 holds the front element.
module pls_cell_row #(
	parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
	input  logic                        clk,
	input  pls_pkg::cell_ctl_t          ctl,
	input  logic [$clog2(CAPACITY)-1:0] idx,
	input  logic [$clog2(CAPACITY)-1:0] last_idx,
	output logic signed [31:0]          head_value
);
	import pls_pkg::*;

	logic signed [31:0] cell_val [CAPACITY];

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [31:0] left_w;
		logic signed [31:0] right_w;

		// edge cells: no left neighbor for the front, tail sees itself
		assign left_w  = (g == 0) ? ctl.ins_value : cell_val[(g == 0) ? 0 : g - 1];
		assign right_w = cell_val[(g == CAPACITY - 1) ? g : g + 1];

		pls_cell #(
			.CAPACITY (CAPACITY),
			.CELL_IDX (g)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.idx         (idx),
			.last_idx    (last_idx),
			.left_value  (left_w),
			.right_value (right_w),
			.head_value  (cell_val[0]),
			.value       (cell_val[g])
		);
	end

	assign head_value = cell_val[0];

endmodule

FILE: design/positional_list_store_unit.sv
// Top level of the positional list store: command decode, length tracking, read-out sequencing.
//
// Bounded ordered list of signed 32-bit elements kept packed in a row of CAPACITY cells,
// front element in cell 0. Every edit (insert or delete at front, back or a 1-based
// position) shifts the cells in parallel, answering with one response word holding the
// status and the new count. A read-out first takes the command, then emits the elements
// front first while the row rotates one step per emitted element, returning to its
// original order after the last one; a stalled response word holds the rotation back.
// Commands are held off (cmd_stall) until the read-out has finished. A read-out of an
// empty list gives one empty-status word. A response register decouples the two sides;
// a command is taken whenever that register is free or being drained.
module positional_list_store_unit #(
	parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  pls_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output pls_pkg::rsp_t rsp
);
	import pls_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = ((LW > 5) ? LW : 5) + 1;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t        state_q, state_d;
	logic [LW-1:0] length_q, length_d;
	logic [IW-1:0] rd_cnt_q, rd_cnt_d;
	logic          rsp_valid_q;
	rsp_t          rsp_q, rsp_d;

	cell_ctl_t          ctl;
	logic [IW-1:0]      idx;
	logic [IW-1:0]      last_idx;
	logic signed [31:0] head_value;

	logic          accept;
	logic          out_free;
	logic          load;
	logic          is_full;
	logic          is_empty;
	logic [CW-1:0] pos_w;
	logic [CW-1:0] len_w;
	logic          ins_pos_ok;
	logic          del_pos_ok;
	logic [1:0]    st;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != S_IDLE) || !out_free;
	assign accept    = cmd_valid && !cmd_stall;

	assign is_full    = (length_q == LW'(CAPACITY));
	assign is_empty   = (length_q == '0);
	assign pos_w      = CW'(cmd.position);
	assign len_w      = CW'(length_q);
	assign ins_pos_ok = (pos_w != '0) && (pos_w <= len_w + CW'(1));
	assign del_pos_ok = (pos_w != '0) && (pos_w <= len_w);
	assign last_idx   = IW'(length_q - LW'(1));

	always_comb begin
		state_d       = state_q;
		length_d      = length_q;
		rd_cnt_d      = rd_cnt_q;
		load          = 1'b0;
		ctl.mode      = CM_HOLD;
		ctl.ins_value = cmd.element_value;
		idx           = '0;
		st            = STS_OK;
		rsp_d         = '0;
		rsp_d.last_result = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					load = 1'b1;
					unique case (cmd.operation) inside
						OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
							if (is_full) begin
								st = STS_FULL;
							end else if (cmd.operation == OP_INS_POS && !ins_pos_ok) begin
								st = STS_INVALID;
							end else begin
								ctl.mode = CM_INS;
								length_d = length_q + LW'(1);
								if (cmd.operation == OP_INS_BACK) begin
									idx = IW'(length_q);
								end else if (cmd.operation == OP_INS_POS) begin
									idx = IW'(pos_w - CW'(1));
								end
							end
						end
						OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
							if (is_empty) begin
								st = STS_EMPTY;
							end else if (cmd.operation == OP_DEL_POS && !del_pos_ok) begin
								st = STS_INVALID;
							end else begin
								ctl.mode = CM_DEL;
								length_d = length_q - LW'(1);
								if (cmd.operation == OP_DEL_BACK) begin
									idx = last_idx;
								end else if (cmd.operation == OP_DEL_POS) begin
									idx = IW'(pos_w - CW'(1));
								end
							end
						end
						OP_READ_ALL: begin
							if (is_empty) begin
								st = STS_EMPTY;
							end else begin
								load     = 1'b0;
								state_d  = S_READ;
								rd_cnt_d = '0;
							end
						end
						default: begin
							st = STS_INVALID;
						end
					endcase
					rsp_d.status        = st;
					rsp_d.element_count = 5'(length_d);
				end
			end
			S_READ: begin
				if (out_free) begin
					load                = 1'b1;
					ctl.mode            = CM_ROT;
					rsp_d.status        = STS_OK;
					rsp_d.element_count = 5'(length_q);
					rsp_d.read_value    = head_value;
					rsp_d.last_result   = (rd_cnt_q == last_idx);
					if (rd_cnt_q == last_idx) begin
						state_d  = S_IDLE;
						rd_cnt_d = '0;
					end else begin
						rd_cnt_d = rd_cnt_q + IW'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			length_q    <= '0;
			rd_cnt_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			length_q <= length_d;
			rd_cnt_q <= rd_cnt_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	pls_cell_row #(
		.CAPACITY (CAPACITY)
	) u_row (
		.clk        (clk),
		.ctl        (ctl),
		.idx        (idx),
		.last_idx   (last_idx),
		.head_value (head_value)
	);

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		length_q <= LW'(CAPACITY))
		else $error("list length above capacity");

	a_read_blocks_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> cmd_stall)
		else $error("command accepted during read-out");

	a_read_len_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> $stable(length_q))
		else $error("length changed during read-out");

	a_read_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> (LW'(rd_cnt_q) < length_q))
		else $error("read-out counter past list end");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");
`endif

endmodule
